// ===== rtl/fcv_pkg.sv =====
// Shared package for the formation consensus velocity block.
// Holds the fixed-point constants, the item kinds, the sequencer states and
// the saturating arithmetic helpers. It depends on nothing else.
package fcv_pkg;

    localparam int NUM_AGENTS_DEF = 5;
    localparam int FRAC_BITS      = 16;
    localparam int Q_W            = 32;
    localparam int WIDE_W         = 66;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [2:0] {
        KIND_REPORT  = 3'd0,
        KIND_COMPUTE = 3'd1,
        KIND_GAIN    = 3'd2,
        KIND_SHAPE   = 3'd3,
        KIND_MASK    = 3'd4,
        KIND_ID      = 3'd5
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SELF_RD,
        ST_SELF_LD,
        ST_L_RD,
        ST_L_LD,
        ST_L_MUL,
        ST_L_ACC,
        ST_DET_M0,
        ST_DET_M1,
        ST_DET_SUB,
        ST_N_M0,
        ST_N_M1,
        ST_N_SUM,
        ST_N_DIV,
        ST_T_RD,
        ST_T_LD,
        ST_T_MUL,
        ST_T_ACC,
        ST_T_WR,
        ST_V_RD,
        ST_V_LD,
        ST_V_MUL,
        ST_V_ACC,
        ST_OUT
    } state_t;

    localparam int ACC_A00 = 0;
    localparam int ACC_A01 = 1;
    localparam int ACC_A11 = 2;
    localparam int ACC_B00 = 3;
    localparam int ACC_B01 = 4;
    localparam int ACC_B10 = 5;
    localparam int ACC_B11 = 6;
    localparam int ACC_T0  = 7;
    localparam int ACC_T1  = 8;
    localparam int ACC_VX  = 9;
    localparam int ACC_VY  = 10;
    localparam int ACC_N   = 11;

    localparam int REG_MISSING = 0;

    function automatic q_t sat32(input wide_t v);
        q_t r;
        if (v > wide_t'(32'sh7fffffff)) begin
            r = 32'sh7fffffff;
        end
        else if (v < wide_t'(32'sh80000000)) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat32(wide_t'(a) - wide_t'(b));
    endfunction

    function automatic q_t qscale(input wide_t p);
        return sat32(p >>> FRAC_BITS);
    endfunction

endpackage

// ===== rtl/fcv_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on fcv_pkg for its default sizes.
module fcv_ram
    import fcv_pkg::*;
#(
    parameter int WIDTH = 2 * Q_W,
    parameter int DEPTH = NUM_AGENTS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fcv_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
// Truncates toward zero and clamps the quotient to 32 bits; uses fcv_pkg.
module fcv_div
    import fcv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output q_t                 quot
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [64:0] rem_sh;
    logic [64:0] diff;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        rem_sh    = {rem_reg[63:0], quo_reg[63]};
        ge        = rem_sh >= {1'b0, den_reg};
        diff      = rem_sh - {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = num[63] ? (~num + 64'd1) : num;
            den_next = den[63] ? (~den + 64'd1) : den;
            neg_next = num[63] ^ den[63];
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff : rem_sh;
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? sat32(-wide_t'({2'b00, quo_reg})) : sat32(wide_t'({2'b00, quo_reg}));

endmodule

// ===== rtl/formation_consensus_velocity.sv =====
// Top level of the formation consensus velocity block: sequencer, datapath,
// APB register and the two RAMs. Depends on fcv_pkg, fcv_ram and fcv_div.
//
// An item is a transaction taken when start is high and busy is low. Table
// writes (gain, shape, mask, id) and position reports finish in the cycle
// they are taken and leave busy low, so they can come back to back. A compute
// item raises busy and ends with one cycle of done carrying the velocity and
// the three flags; the receiver always takes it. The velocity pass visits each
// neighbour in the agent's mask in turn on the shared multiplier; when the
// missing agent is a neighbour, a least squares pass runs before it on the same
// multiplier, with four divisions in the bit-serial divider unless the system
// is singular. An unknown id gives done in the cycle right after the
// accepting edge.
// The missing_slot register is written over APB at byte address 0; the user
// must write it only while the block is idle, which the block itself does not
// enforce. Reset marks all positions as zero, sets missing_slot to NUM_AGENTS
// (no agent missing) and returns the sequencer to idle; the other tables hold
// nothing useful until written.
module formation_consensus_velocity
    import fcv_pkg::*;
#(
    parameter int NUM_AGENTS = NUM_AGENTS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  agent_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [2:0]  row_index,
    input  logic [2:0]  col_index,
    input  logic signed [31:0] table_word,
    output logic        done,
    output logic signed [31:0] velocity_x,
    output logic signed [31:0] velocity_y,
    output logic        id_known,
    output logic        localized,
    output logic        singular,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W      = $clog2(NUM_AGENTS);
    localparam int CNT_W      = $clog2(NUM_AGENTS + 1);
    localparam int MISS_W     = (CNT_W > 3) ? CNT_W : 3;
    localparam int COEF_DEPTH = NUM_AGENTS * NUM_AGENTS + NUM_AGENTS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam logic [COEF_AW-1:0] SHAPE_BASE = COEF_AW'(NUM_AGENTS * NUM_AGENTS);
    localparam logic signed [64:0] TRUNC_BIAS = (65'sd1 <<< FRAC_BITS) - 65'sd1;

    state_t state_reg, state_next;

    logic [MISS_W-1:0]     miss_reg, miss_next;
    logic [NUM_AGENTS-1:0] pos_valid_reg, pos_valid_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [2:0]            op_reg, op_next;
    logic [1:0]            rc_reg, rc_next;

    logic [7:0]            id_reg [NUM_AGENTS];
    logic [NUM_AGENTS-1:0] mask_reg [NUM_AGENTS];
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  known_reg, known_next;
    logic [NUM_AGENTS-1:0] nb_reg, nb_next;
    logic                  loc_req_reg, loc_req_next;
    logic                  loc_reg, loc_next;
    logic                  sing_reg, sing_next;
    q_t                    cx_reg, cx_next;
    q_t                    cy_reg, cy_next;
    q_t                    shx_reg, shx_next;
    q_t                    shy_reg, shy_next;
    q_t                    hx_reg, hx_next;
    q_t                    hy_reg, hy_next;
    q_t                    xx_reg, xx_next;
    q_t                    xy_reg, xy_next;
    q_t                    acc_reg [ACC_N];
    q_t                    acc_next [ACC_N];
    q_t                    theta_reg [4];
    q_t                    theta_next [4];
    wide_t                 prod_reg, prod_next;
    logic signed [63:0]    wide_reg, wide_next;
    logic signed [63:0]    dq_reg, dq_next;

    logic                  accept;
    logic                  hit;
    logic [IDX_W-1:0]      hit_slot;
    logic                  miss_valid;
    logic [IDX_W-1:0]      miss_idx;
    logic [IDX_W-1:0]      k_idx;
    logic                  row_ok;
    logic                  col_ok;
    logic                  loc_req_now;
    logic                  k_end;

    logic                  pos_we;
    logic [IDX_W-1:0]      pos_waddr;
    logic [2*Q_W-1:0]      pos_wdata;
    logic [IDX_W-1:0]      pos_raddr;
    logic [2*Q_W-1:0]      pos_rdata;
    logic                  coef_we;
    logic [COEF_AW-1:0]    coef_waddr;
    logic [2*Q_W-1:0]      coef_wdata;
    logic [COEF_AW-1:0]    coef_raddr;
    logic [2*Q_W-1:0]      coef_rdata;

    q_t                    rd_cx, rd_cy, rd_px, rd_py;
    logic signed [32:0]    mul_a, mul_b;
    logic signed [32:0]    neg_a01;
    q_t                    q_now;
    int                    acc_dst;
    logic signed [64:0]    det;
    logic signed [64:0]    dq_calc;
    logic signed [64:0]    nsum;
    logic signed [63:0]    nsat;
    logic                  div_start;
    logic                  div_done;
    q_t                    div_quot;

    assign accept     = start && !busy;
    assign busy       = (state_reg != ST_IDLE);
    assign miss_valid = (int'(miss_reg) < NUM_AGENTS);
    assign miss_idx   = miss_reg[IDX_W-1:0];
    assign k_idx      = k_reg[IDX_W-1:0];
    assign k_end      = (int'(k_reg) == NUM_AGENTS);
    assign row_ok     = (int'(row_index) < NUM_AGENTS);
    assign col_ok     = (int'(col_index) < NUM_AGENTS);
    assign loc_req_now = miss_valid && mask_reg[hit_slot][miss_idx];

    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int s = NUM_AGENTS - 1; s >= 0; s--)
        begin
            if (id_reg[s] == agent_id)
            begin
                hit      = 1'b1;
                hit_slot = IDX_W'(s);
            end
        end
    end

    fcv_ram #(
        .WIDTH(2 * Q_W),
        .DEPTH(NUM_AGENTS)
    ) u_pos_ram (
        .clk(clk),
        .we(pos_we),
        .waddr(pos_waddr),
        .wdata(pos_wdata),
        .raddr(pos_raddr),
        .rdata(pos_rdata)
    );

    fcv_ram #(
        .WIDTH(2 * Q_W),
        .DEPTH(COEF_DEPTH)
    ) u_coef_ram (
        .clk(clk),
        .we(coef_we),
        .waddr(coef_waddr),
        .wdata(coef_wdata),
        .raddr(coef_raddr),
        .rdata(coef_rdata)
    );

    fcv_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(nsat),
        .den(dq_reg),
        .done(div_done),
        .quot(div_quot)
    );

    assign rd_cx = coef_rdata[Q_W-1:0];
    assign rd_cy = coef_rdata[2*Q_W-1:Q_W];
    assign rd_px = pos_valid_reg[k_idx] ? q_t'(pos_rdata[Q_W-1:0]) : q_t'(0);
    assign rd_py = pos_valid_reg[k_idx] ? q_t'(pos_rdata[2*Q_W-1:Q_W]) : q_t'(0);
    assign q_now = qscale(prod_reg);
    assign neg_a01 = -(33'(acc_reg[ACC_A01]));
    assign det     = 65'(wide_reg) - 65'($signed(prod_reg[63:0]));
    assign dq_calc = det[64] ? ((det + TRUNC_BIAS) >>> FRAC_BITS) : (det >>> FRAC_BITS);
    assign nsum    = 65'(wide_reg) + 65'($signed(prod_reg[63:0]));
    assign div_start = (state_reg == ST_N_SUM);

    always_comb
    begin
        if (nsum > 65'sh0_7fff_ffff_ffff_ffff)
        begin
            nsat = 64'sh7fff_ffff_ffff_ffff;
        end
        else if (nsum < -65'sh0_8000_0000_0000_0000)
        begin
            nsat = 64'sh8000_0000_0000_0000;
        end
        else
        begin
            nsat = nsum[63:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_L_MUL:
            begin
                unique case (op_reg)
                    3'd0: begin mul_a = 33'(hx_reg); mul_b = 33'(hx_reg); end
                    3'd1: begin mul_a = 33'(hx_reg); mul_b = 33'(hy_reg); end
                    3'd2: begin mul_a = 33'(hy_reg); mul_b = 33'(hy_reg); end
                    3'd3: begin mul_a = 33'(hx_reg); mul_b = 33'(xx_reg); end
                    3'd4: begin mul_a = 33'(hx_reg); mul_b = 33'(xy_reg); end
                    3'd5: begin mul_a = 33'(hy_reg); mul_b = 33'(xx_reg); end
                    default: begin mul_a = 33'(hy_reg); mul_b = 33'(xy_reg); end
                endcase
            end
            ST_DET_M0:
            begin
                mul_a = 33'(acc_reg[ACC_A00]);
                mul_b = 33'(acc_reg[ACC_A11]);
            end
            ST_DET_M1:
            begin
                mul_a = 33'(acc_reg[ACC_A01]);
                mul_b = 33'(acc_reg[ACC_A01]);
            end
            ST_N_M0:
            begin
                mul_a = rc_reg[1] ? neg_a01 : 33'(acc_reg[ACC_A11]);
                mul_b = rc_reg[0] ? 33'(acc_reg[ACC_B01]) : 33'(acc_reg[ACC_B00]);
            end
            ST_N_M1:
            begin
                mul_a = rc_reg[1] ? 33'(acc_reg[ACC_A00]) : neg_a01;
                mul_b = rc_reg[0] ? 33'(acc_reg[ACC_B11]) : 33'(acc_reg[ACC_B10]);
            end
            ST_T_MUL:
            begin
                unique case (op_reg)
                    3'd0: begin mul_a = 33'(theta_reg[0]); mul_b = 33'(hx_reg); end
                    3'd1: begin mul_a = 33'(theta_reg[2]); mul_b = 33'(hy_reg); end
                    3'd2: begin mul_a = 33'(theta_reg[1]); mul_b = 33'(hx_reg); end
                    default: begin mul_a = 33'(theta_reg[3]); mul_b = 33'(hy_reg); end
                endcase
            end
            ST_V_MUL:
            begin
                mul_a = 33'(hx_reg);
                mul_b = (op_reg == 3'd0) ? 33'(xx_reg) : 33'(xy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_COMPUTE)
                begin
                    if (!hit)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (loc_req_now)
                    begin
                        state_next = ST_SELF_RD;
                    end
                    else
                    begin
                        state_next = ST_V_RD;
                    end
                end
            end
            ST_SELF_RD: state_next = ST_SELF_LD;
            ST_SELF_LD: state_next = ST_L_RD;
            ST_L_RD:
            begin
                if (k_end)
                begin
                    state_next = ST_DET_M0;
                end
                else if (nb_reg[k_idx] && k_idx != miss_idx)
                begin
                    state_next = ST_L_LD;
                end
            end
            ST_L_LD:    state_next = ST_L_MUL;
            ST_L_MUL:   state_next = ST_L_ACC;
            ST_L_ACC:   state_next = (op_reg == 3'd6) ? ST_L_RD : ST_L_MUL;
            ST_DET_M0:  state_next = ST_DET_M1;
            ST_DET_M1:  state_next = ST_DET_SUB;
            ST_DET_SUB: state_next = (dq_calc == '0) ? ST_V_RD : ST_N_M0;
            ST_N_M0:    state_next = ST_N_M1;
            ST_N_M1:    state_next = ST_N_SUM;
            ST_N_SUM:   state_next = ST_N_DIV;
            ST_N_DIV:
            begin
                if (div_done)
                begin
                    state_next = (rc_reg == 2'd3) ? ST_T_RD : ST_N_M0;
                end
            end
            ST_T_RD:    state_next = ST_T_LD;
            ST_T_LD:    state_next = ST_T_MUL;
            ST_T_MUL:   state_next = ST_T_ACC;
            ST_T_ACC:   state_next = (op_reg == 3'd3) ? ST_T_WR : ST_T_MUL;
            ST_T_WR:    state_next = ST_V_RD;
            ST_V_RD:
            begin
                if (k_end)
                begin
                    state_next = ST_OUT;
                end
                else if (nb_reg[k_idx])
                begin
                    state_next = ST_V_LD;
                end
            end
            ST_V_LD:    state_next = ST_V_MUL;
            ST_V_MUL:   state_next = ST_V_ACC;
            ST_V_ACC:   state_next = (op_reg == 3'd1) ? ST_V_RD : ST_V_MUL;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory ports and register updates.
    always_comb
    begin
        miss_next      = miss_reg;
        pos_valid_next = pos_valid_reg;
        k_next         = k_reg;
        op_next        = op_reg;
        rc_next        = rc_reg;
        slot_next      = slot_reg;
        known_next     = known_reg;
        nb_next        = nb_reg;
        loc_req_next   = loc_req_reg;
        loc_next       = loc_reg;
        sing_next      = sing_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        shx_next       = shx_reg;
        shy_next       = shy_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        xx_next        = xx_reg;
        xy_next        = xy_reg;
        acc_next       = acc_reg;
        theta_next     = theta_reg;
        prod_next      = mul_a * mul_b;
        wide_next      = wide_reg;
        dq_next        = dq_reg;
        acc_dst        = ACC_A00;

        pos_we     = 1'b0;
        pos_waddr  = hit_slot;
        pos_wdata  = {pos_y, pos_x};
        pos_raddr  = k_idx;
        coef_we    = 1'b0;
        coef_waddr = COEF_AW'(int'(row_index) * NUM_AGENTS + int'(col_index));
        coef_wdata = {32'd0, table_word};
        coef_raddr = SHAPE_BASE + COEF_AW'(k_idx);

        if (psel && penable && pwrite && !paddr[2])
        begin
            miss_next = MISS_W'(pwdata[2:0]);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_REPORT:
                        begin
                            if (hit && !(miss_valid && hit_slot == miss_idx))
                            begin
                                pos_we                   = 1'b1;
                                pos_valid_next[hit_slot] = 1'b1;
                            end
                        end
                        KIND_COMPUTE:
                        begin
                            known_next   = hit;
                            slot_next    = hit_slot;
                            nb_next      = mask_reg[hit_slot];
                            loc_req_next = loc_req_now;
                            loc_next     = 1'b0;
                            sing_next    = 1'b0;
                            cx_next      = pos_x;
                            cy_next      = pos_y;
                            k_next       = '0;
                            op_next      = '0;
                            rc_next      = '0;
                            for (int a = 0; a < ACC_N; a++)
                            begin
                                acc_next[a] = '0;
                            end
                        end
                        KIND_GAIN:
                        begin
                            coef_we = row_ok && col_ok;
                        end
                        KIND_SHAPE:
                        begin
                            coef_we    = row_ok;
                            coef_waddr = SHAPE_BASE + COEF_AW'(row_index[IDX_W-1:0]);
                            coef_wdata = {pos_y, pos_x};
                        end
                        default:
                        begin
                            coef_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_SELF_RD:
            begin
                coef_raddr = SHAPE_BASE + COEF_AW'(slot_reg);
            end
            ST_SELF_LD:
            begin
                shx_next = rd_cx;
                shy_next = rd_cy;
            end
            ST_L_RD:
            begin
                if (!k_end && !(nb_reg[k_idx] && k_idx != miss_idx))
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_L_LD:
            begin
                hx_next = qsub(shx_reg, rd_cx);
                hy_next = qsub(shy_reg, rd_cy);
                xx_next = qsub(cx_reg, rd_px);
                xy_next = qsub(cy_reg, rd_py);
                op_next = '0;
            end
            ST_L_ACC:
            begin
                acc_dst           = int'(op_reg);
                acc_next[acc_dst] = sat32(wide_t'(acc_reg[acc_dst]) + wide_t'(q_now));
                if (op_reg == 3'd6)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    op_next = op_reg + 3'd1;
                end
            end
            ST_DET_M1:
            begin
                wide_next = prod_reg[63:0];
            end
            ST_DET_SUB:
            begin
                dq_next = dq_calc[63:0];
                rc_next = '0;
                k_next  = '0;
                if (dq_calc == '0)
                begin
                    sing_next = 1'b1;
                end
            end
            ST_N_M1:
            begin
                wide_next = prod_reg[63:0];
            end
            ST_N_DIV:
            begin
                if (div_done)
                begin
                    theta_next[rc_reg] = div_quot;
                    rc_next            = rc_reg + 2'd1;
                end
            end
            ST_T_RD:
            begin
                coef_raddr = SHAPE_BASE + COEF_AW'(miss_idx);
            end
            ST_T_LD:
            begin
                hx_next = qsub(shx_reg, rd_cx);
                hy_next = qsub(shy_reg, rd_cy);
                op_next = '0;
            end
            ST_T_ACC:
            begin
                acc_dst           = (op_reg < 3'd2) ? ACC_T0 : ACC_T1;
                acc_next[acc_dst] = sat32(wide_t'(acc_reg[acc_dst]) + wide_t'(q_now));
                op_next           = op_reg + 3'd1;
            end
            ST_T_WR:
            begin
                pos_we                   = 1'b1;
                pos_waddr                = miss_idx;
                pos_wdata                = {qsub(cy_reg, acc_reg[ACC_T1]),
                                            qsub(cx_reg, acc_reg[ACC_T0])};
                pos_valid_next[miss_idx] = 1'b1;
                loc_next                 = 1'b1;
                k_next                   = '0;
            end
            ST_V_RD:
            begin
                coef_raddr = COEF_AW'(int'(slot_reg) * NUM_AGENTS + int'(k_idx));
                if (!k_end && !nb_reg[k_idx])
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_V_LD:
            begin
                hx_next = rd_cx;
                xx_next = qsub(cx_reg, rd_px);
                xy_next = qsub(cy_reg, rd_py);
                op_next = '0;
            end
            ST_V_ACC:
            begin
                acc_dst           = (op_reg == 3'd0) ? ACC_VX : ACC_VY;
                acc_next[acc_dst] = sat32(wide_t'(acc_reg[acc_dst]) + wide_t'(q_now));
                if (op_reg == 3'd1)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    op_next = op_reg + 3'd1;
                end
            end
            default:
            begin
                acc_dst = ACC_A00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            miss_reg      <= MISS_W'(NUM_AGENTS);
            pos_valid_reg <= '0;
            k_reg         <= '0;
            op_reg        <= '0;
            rc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            miss_reg      <= miss_next;
            pos_valid_reg <= pos_valid_next;
            k_reg         <= k_next;
            op_reg        <= op_next;
            rc_reg        <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        known_reg   <= known_next;
        nb_reg      <= nb_next;
        loc_req_reg <= loc_req_next;
        loc_reg     <= loc_next;
        sing_reg    <= sing_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        shx_reg     <= shx_next;
        shy_reg     <= shy_next;
        hx_reg      <= hx_next;
        hy_reg      <= hy_next;
        xx_reg      <= xx_next;
        xy_reg      <= xy_next;
        acc_reg     <= acc_next;
        theta_reg   <= theta_next;
        prod_reg    <= prod_next;
        wide_reg    <= wide_next;
        dq_reg      <= dq_next;
        if (accept && kind == KIND_MASK && row_ok)
        begin
            mask_reg[row_index[IDX_W-1:0]] <= table_word[NUM_AGENTS-1:0];
        end
        if (accept && kind == KIND_ID && row_ok)
        begin
            id_reg[row_index[IDX_W-1:0]] <= table_word[7:0];
        end
    end

    assign done       = (state_reg == ST_OUT);
    assign velocity_x = acc_reg[ACC_VX];
    assign velocity_y = acc_reg[ACC_VY];
    assign id_known   = known_reg;
    assign localized  = loc_reg;
    assign singular   = sing_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == 1'b0) ? 32'(miss_reg) : 32'd0;

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !id_known) |-> (velocity_x == 0 && velocity_y == 0 && !localized && !singular))
        else $error("unknown id result is not zero");

    a_loc_sing: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(localized && singular))
        else $error("localized and singular both set");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_COMPUTE) |=> busy)
        else $error("compute transaction did not raise busy");

    a_estimate_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_WR) |-> (miss_valid && loc_req_reg && !sing_reg))
        else $error("estimate written without a valid missing slot");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for formation_consensus_velocity.
// It drives table writes, position reports and compute transactions, predicts
// each result in place, and depends only on fcv_pkg and the block itself.
module tb
    import fcv_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NA = NUM_AGENTS_DEF;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int WATCH_LIMIT = 20000;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        bit known;
        bit loc;
        bit sing;
    } velocity_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] id;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [2:0] row;
        logic [2:0] col;
        logic signed [31:0] word;
        bit fixed;
        velocity_t res;
    } command_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] kind = KIND_REPORT;
    logic [7:0] agent_id = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic [2:0] row_index = '0;
    logic [2:0] col_index = '0;
    logic signed [31:0] table_word = '0;
    logic done;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic id_known;
    logic localized;
    logic singular;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    formation_consensus_velocity uut (.*);

    always #4 clk = ~clk;

    int errors = 0;
    int idle_cycles = 0;
    velocity_t pending_velocities[$];

    int ids_m[NA];
    longint gain_m[NA][NA];
    bit [NA-1:0] mask_m[NA];
    longint shape_x[NA];
    longint shape_y[NA];
    longint at_x[NA];
    longint at_y[NA];
    int unsigned missing_m = NA;

    function automatic longint clamp32(longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint fxsub(longint a, longint b);
        return clamp32(a - b);
    endfunction

    function automatic longint add64_sat(longint a, longint b);
        longint r;
        r = a + b;
        if (a > 0 && b > 0 && r < 0) return 64'h7fffffffffffffff;
        if (a < 0 && b < 0 && r >= 0) return 64'h8000000000000000;
        return r;
    endfunction

    function automatic int slot_of(logic [7:0] id);
        for (int s = 0; s < NA; s++)
        begin
            if (ids_m[s] == id) return s;
        end
        return NA;
    endfunction

    // Least squares re-estimate of the missing agent; returns 1 when singular.
    function automatic bit estimate_missing(int i, longint cx, longint cy);
        longint a00, a01, a11, det, dq, n, d0, d1, t0, t1;
        longint bm[2][2];
        longint adj[2][2];
        longint th[2][2];
        longint hx, hy, xx, xy;
        int m;
        m = missing_m;
        a00 = 0;
        a01 = 0;
        a11 = 0;
        bm = '{'{0, 0}, '{0, 0}};
        for (int k = 0; k < NA; k++)
        begin
            if (!mask_m[i][k] || k == m) continue;
            hx = fxsub(shape_x[i], shape_x[k]);
            hy = fxsub(shape_y[i], shape_y[k]);
            xx = fxsub(cx, at_x[k]);
            xy = fxsub(cy, at_y[k]);
            a00 = clamp32(a00 + fxmul(hx, hx));
            a01 = clamp32(a01 + fxmul(hx, hy));
            a11 = clamp32(a11 + fxmul(hy, hy));
            bm[0][0] = clamp32(bm[0][0] + fxmul(hx, xx));
            bm[0][1] = clamp32(bm[0][1] + fxmul(hx, xy));
            bm[1][0] = clamp32(bm[1][0] + fxmul(hy, xx));
            bm[1][1] = clamp32(bm[1][1] + fxmul(hy, xy));
        end
        det = a00 * a11 - a01 * a01;
        dq = det / (64'sd1 <<< FRAC_BITS);
        if (dq == 0) return 1'b1;
        adj[0][0] = a11;
        adj[0][1] = -a01;
        adj[1][0] = -a01;
        adj[1][1] = a00;
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                n = add64_sat(adj[r][0] * bm[0][c], adj[r][1] * bm[1][c]);
                if (dq == -1) th[r][c] = clamp32(n == 64'h8000000000000000 ? MAX32 : -n);
                else th[r][c] = clamp32(n / dq);
            end
        end
        d0 = fxsub(shape_x[i], shape_x[m]);
        d1 = fxsub(shape_y[i], shape_y[m]);
        t0 = clamp32(fxmul(th[0][0], d0) + fxmul(th[1][0], d1));
        t1 = clamp32(fxmul(th[0][1], d0) + fxmul(th[1][1], d1));
        at_x[m] = fxsub(cx, t0);
        at_y[m] = fxsub(cy, t1);
        return 1'b0;
    endfunction

    // Updates the tables for one transaction; returns 1 with the velocity for a compute.
    function automatic bit predict_velocity(command_t c, output velocity_t v);
        int s;
        longint vx, vy, g;
        v = '{0, 0, 0, 0, 0};
        case (c.kind)
            KIND_REPORT:
            begin
                s = slot_of(c.id);
                if (s < NA && s != missing_m)
                begin
                    at_x[s] = c.px;
                    at_y[s] = c.py;
                end
                return 1'b0;
            end
            KIND_GAIN:
            begin
                if (c.row < NA && c.col < NA) gain_m[c.row][c.col] = c.word;
                return 1'b0;
            end
            KIND_SHAPE:
            begin
                if (c.row < NA)
                begin
                    shape_x[c.row] = c.px;
                    shape_y[c.row] = c.py;
                end
                return 1'b0;
            end
            KIND_MASK:
            begin
                if (c.row < NA) mask_m[c.row] = c.word[NA-1:0];
                return 1'b0;
            end
            KIND_ID:
            begin
                if (c.row < NA) ids_m[c.row] = c.word[7:0];
                return 1'b0;
            end
            KIND_COMPUTE:
            begin
                s = slot_of(c.id);
                if (s < NA)
                begin
                    v.known = 1'b1;
                    if (missing_m < NA && mask_m[s][missing_m])
                    begin
                        v.sing = estimate_missing(s, c.px, c.py);
                        v.loc = !v.sing;
                    end
                    vx = 0;
                    vy = 0;
                    for (int j = 0; j < NA; j++)
                    begin
                        if (!mask_m[s][j]) continue;
                        g = gain_m[s][j];
                        vx = clamp32(vx + fxmul(g, fxsub(c.px, at_x[j])));
                        vy = clamp32(vy + fxmul(g, fxsub(c.py, at_y[j])));
                    end
                    v.vx = vx[31:0];
                    v.vy = vy[31:0];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic issue(command_t c, int idle_pct);
        velocity_t v;
        start <= 1'b1;
        kind <= c.kind;
        agent_id <= c.id;
        pos_x <= c.px;
        pos_y <= c.py;
        row_index <= c.row;
        col_index <= c.col;
        table_word <= c.word;
        do @(posedge clk); while (busy);
        if (predict_velocity(c, v)) pending_velocities.push_back(c.fixed ? c.res : v);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic settle_and_set_missing(int unsigned value);
        start <= 1'b0;
        while (pending_velocities.size() != 0 || busy) @(posedge clk);
        repeat (10) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(REG_MISSING * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        missing_m = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[2:0] != value[2:0])
        begin
            $error("missing_slot readback: expected %0d actual %0d", value, prdata[2:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [31:0] near_q();
        if ($urandom_range(9) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    function automatic command_t random_command();
        command_t c;
        int pick;
        pick = $urandom_range(99);
        c.kind = pick < 30 ? KIND_REPORT : pick < 62 ? KIND_COMPUTE : pick < 72 ? KIND_GAIN :
                 pick < 80 ? KIND_SHAPE : pick < 88 ? KIND_MASK : pick < 94 ? KIND_ID :
                 pick < 97 ? KIND_SPARE_A : KIND_SPARE_B;
        c.id = $urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(10, 14));
        c.px = near_q();
        c.py = near_q();
        c.row = $urandom_range(9) == 0 ? 3'($urandom) : 3'($urandom_range(NA - 1));
        c.col = $urandom_range(9) == 0 ? 3'($urandom) : 3'($urandom_range(NA - 1));
        c.word = $urandom;
        if (c.kind == KIND_GAIN && $urandom_range(3) != 0)
            c.word = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        if (c.kind == KIND_ID && $urandom_range(4) != 0)
            c.word[7:0] = 8'($urandom_range(10, 14));
        c.fixed = 1'b0;
        return c;
    endfunction

    always @(posedge clk)
    begin
        velocity_t e;
        if (done)
        begin
            if (pending_velocities.size() == 0)
            begin
                $error("result with no compute transaction outstanding");
                errors++;
            end
            else
            begin
                e = pending_velocities.pop_front();
                if (velocity_x !== e.vx)
                begin
                    $error("velocity_x: expected %0d actual %0d", e.vx, velocity_x);
                    errors++;
                end
                if (velocity_y !== e.vy)
                begin
                    $error("velocity_y: expected %0d actual %0d", e.vy, velocity_y);
                    errors++;
                end
                if (id_known !== e.known)
                begin
                    $error("id_known: expected %0d actual %0d", e.known, id_known);
                    errors++;
                end
                if (localized !== e.loc)
                begin
                    $error("localized: expected %0d actual %0d", e.loc, localized);
                    errors++;
                end
                if (singular !== e.sing)
                begin
                    $error("singular: expected %0d actual %0d", e.sing, singular);
                    errors++;
                end
            end
        end
        if (done || (start && !busy) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    localparam velocity_t NO_AGENT = '{0, 0, 0, 0, 0};
    localparam velocity_t STILL = '{0, 0, 1, 0, 0};

    command_t directed[] = '{
        '{KIND_COMPUTE, 200, 0, 0, 0, 0, 0, 1, NO_AGENT},
        '{KIND_COMPUTE, 10, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 1, STILL},
        '{KIND_MASK, 0, 0, 0, 0, 0, 32'hffffffe3, 0, NO_AGENT},
        '{KIND_GAIN, 0, 0, 0, 0, 1, 32'sh7fffffff, 0, NO_AGENT},
        '{KIND_GAIN, 0, 0, 0, 0, 0, 32'sh80000000, 0, NO_AGENT},
        '{KIND_REPORT, 11, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, NO_AGENT},
        '{KIND_COMPUTE, 10, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, NO_AGENT},
        '{KIND_GAIN, 0, 0, 0, 5, 0, 32'sh00010000, 0, NO_AGENT},
        '{KIND_GAIN, 0, 0, 0, 0, 7, 32'sh00010000, 0, NO_AGENT},
        '{KIND_SHAPE, 0, 32'sh00050000, 32'sh00050000, 7, 0, 0, 0, NO_AGENT},
        '{KIND_MASK, 0, 0, 0, 6, 0, 32'h1f, 0, NO_AGENT},
        '{KIND_ID, 0, 0, 0, 5, 0, 32'h0a, 0, NO_AGENT},
        '{KIND_SPARE_A, 10, 0, 0, 0, 0, 0, 0, NO_AGENT},
        '{KIND_SPARE_B, 10, 0, 0, 0, 0, 0, 0, NO_AGENT},
        '{KIND_ID, 0, 0, 0, 3, 0, 32'hffffff0b, 0, NO_AGENT},
        '{KIND_REPORT, 11, 32'sh00010000, -32'sh00010000, 0, 0, 0, 0, NO_AGENT},
        '{KIND_COMPUTE, 11, 0, 0, 0, 0, 0, 1, STILL},
        '{KIND_ID, 0, 0, 0, 3, 0, 32'h0d, 0, NO_AGENT},
        '{KIND_COMPUTE, 10, 0, 0, 0, 0, 0, 0, NO_AGENT},
        '{KIND_REPORT, 255, 32'sh00030000, 0, 0, 0, 0, 0, NO_AGENT},
        '{KIND_COMPUTE, 255, 0, 0, 0, 0, 0, 1, NO_AGENT}
    };

    int unsigned missing_plan[5] = '{5, 0, 4, 2, 5};
    int idle_plan[5] = '{0, 81, 7, 0, 81};

    initial
    begin
        command_t c;
        int wait_cycles;
        for (int s = 0; s < NA; s++)
        begin
            ids_m[s] = 0;
            mask_m[s] = '0;
            shape_x[s] = 0;
            shape_y[s] = 0;
            at_x[s] = 0;
            at_y[s] = 0;
            for (int j = 0; j < NA; j++) gain_m[s][j] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int s = 0; s < NA; s++)
        begin
            issue('{KIND_ID, 0, 0, 0, 3'(s), 0, 32'(10 + s), 0, NO_AGENT}, 0);
            issue('{KIND_MASK, 0, 0, 0, 3'(s), 0, 0, 0, NO_AGENT}, 0);
            issue('{KIND_SHAPE, 0, 0, 0, 3'(s), 0, 0, 0, NO_AGENT}, 0);
            for (int j = 0; j < NA; j++)
                issue('{KIND_GAIN, 0, 0, 0, 3'(s), 3'(j), 0, 0, NO_AGENT}, 0);
        end
        foreach (directed[r]) issue(directed[r], 0);
        for (int s = 0; s < NA; s++)
        begin
            issue('{KIND_SHAPE, 0, near_q(), near_q(), 3'(s), 0, 0, 0, NO_AGENT}, 0);
            issue('{KIND_MASK, 0, 0, 0, 3'(s), 0, 32'($urandom), 0, NO_AGENT}, 0);
        end
        for (int p = 0; p < 5; p++)
        begin
            settle_and_set_missing(missing_plan[p]);
            for (int n = 0; n < 120; n++)
            begin
                c = random_command();
                issue(c, idle_plan[p]);
            end
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_velocities.size() != 0 && wait_cycles < WATCH_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_velocities.size() == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/fcv_pkg.sv
rtl/fcv_ram.sv
rtl/fcv_div.sv
rtl/formation_consensus_velocity.sv
verif/tb.sv
